[design/pip_pkg.sv]
`default_nettype none

package pip_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;

  // Width of the result stream's data bus: one flag padded to a byte.
  localparam int OUT_BITS = 8;

  // Values of the command field.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Decoded kind of a queued item.
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_SKIP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

[design/pip_ram.sv]
`default_nettype none

module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/pip_front.sv]
`default_nettype none

module pip_front
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  localparam int IDX_BITS = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int CNT_BITS = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_command,
  input  wire logic [IDX_BITS-1:0]   in_index,
  input  wire logic [COORD_BITS-1:0] in_x,
  input  wire logic [COORD_BITS-1:0] in_y,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output op_t                        q_op,
  output logic [IDX_BITS-1:0]        q_index,
  output logic [COORD_BITS-1:0]      q_x,
  output logic [COORD_BITS-1:0]      q_y
);

  localparam int PL_BITS = IDX_BITS + 2 * COORD_BITS;
  localparam logic [CNT_BITS-1:0] MAX_N = CNT_BITS'(MAX_VERTICES);

  op_t               op_mem [2];
  logic [PL_BITS-1:0] pl_mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        level;
  logic              push;
  logic              pop;
  op_t               in_op;
  logic [PL_BITS-1:0] head;

  // Classify: writes beyond the store are dropped at the back.
  always_comb begin
    if (in_command == CMD_QUERY) begin
      in_op = OP_QUERY;
    end else if ({1'b0, in_index} < MAX_N) begin
      in_op = OP_WRITE;
    end else begin
      in_op = OP_SKIP;
    end
  end

  assign in_ready = (level != 2'd2);
  assign q_valid  = (level != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  assign q_op    = op_mem[rd_ptr];
  assign head    = pl_mem[rd_ptr];
  assign q_index = head[IDX_BITS-1:0];
  assign q_x     = head[IDX_BITS +: COORD_BITS];
  assign q_y     = head[IDX_BITS + COORD_BITS +: COORD_BITS];

  always_ff @(posedge clk) begin
    if (push) begin
      op_mem[wr_ptr] <= in_op;
      pl_mem[wr_ptr] <= {in_y, in_x, in_index};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/pip_back.sv]
`default_nettype none

module pip_back
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  localparam int IDX_BITS = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int CNT_BITS = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [CNT_BITS-1:0]   n_use,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire op_t                   q_op,
  input  wire logic [IDX_BITS-1:0]   q_index,
  input  wire logic [COORD_BITS-1:0] q_x,
  input  wire logic [COORD_BITS-1:0] q_y,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output logic                       res_inside
);

  localparam int CB = COORD_BITS;

  back_state_t state, state_next;

  logic                 wr_en;
  logic                 rd_en;
  logic                 start;
  logic                 load_out;
  logic [2*CB-1:0]      rd_data;
  logic [IDX_BITS-1:0]  addr;
  logic [IDX_BITS-1:0]  last_addr;
  logic                 first;
  logic                 issue_last;

  logic signed [CB-1:0] px;
  logic signed [CB-1:0] py;
  logic signed [CB-1:0] xi;
  logic signed [CB-1:0] yi;
  logic signed [CB-1:0] xj;
  logic signed [CB-1:0] yj;
  logic [2*CB-1:0]      vprev;

  logic                 rd_v;
  logic                 rd_first;
  logic                 rd_last;

  logic                 s1_v;
  logic                 s1_last;
  logic                 s1_str;
  logic                 s1_dypos;
  logic signed [CB:0]   s1_dxp;
  logic signed [CB:0]   s1_dy;
  logic signed [CB:0]   s1_dxe;
  logic signed [CB:0]   s1_dyp;

  logic                 s2_v;
  logic                 s2_last;
  logic                 s2_str;
  logic                 s2_dypos;
  logic signed [2*CB+1:0] s2_lhs;
  logic signed [2*CB+1:0] s2_rhs;
  logic                 left;

  logic                 parity;

  pip_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (q_index),
    .wr_data ({q_y, q_x}),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign last_addr  = IDX_BITS'(n_use - CNT_BITS'(1));
  assign issue_last = !first && (addr == last_addr);

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    start      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_ready = 1'b1;
          unique case (q_op)
            OP_WRITE: wr_en = 1'b1;
            OP_QUERY: begin
              start      = 1'b1;
              state_next = (n_use == '0) ? ST_DONE : ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        rd_en = 1'b1;
        if (issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_v && s2_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || res_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Read order: last vertex first to seed the previous-vertex register, then 0 .. n-1.
  always_ff @(posedge clk) begin
    if (start) begin
      addr  <= last_addr;
      first <= 1'b1;
      px    <= q_x;
      py    <= q_y;
    end else if (rd_en) begin
      first <= 1'b0;
      addr  <= first ? '0 : addr + IDX_BITS'(1);
    end
  end

  assign xi = rd_data[CB-1:0];
  assign yi = rd_data[2*CB-1:CB];
  assign xj = vprev[CB-1:0];
  assign yj = vprev[2*CB-1:CB];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      rd_v <= rd_en;
      s1_v <= rd_v && !rd_first;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= first;
    rd_last  <= rd_en && issue_last;
    if (rd_v) begin
      vprev <= rd_data;
    end
    s1_last  <= rd_last;
    s1_str   <= (yi > py) != (yj > py);
    s1_dypos <= yj > yi;
    s1_dxp   <= $signed({px[CB-1], px}) - $signed({xi[CB-1], xi});
    s1_dy    <= $signed({yj[CB-1], yj}) - $signed({yi[CB-1], yi});
    s1_dxe   <= $signed({xj[CB-1], xj}) - $signed({xi[CB-1], xi});
    s1_dyp   <= $signed({py[CB-1], py}) - $signed({yi[CB-1], yi});
    s2_last  <= s1_last;
    s2_str   <= s1_str;
    s2_dypos <= s1_dypos;
    s2_lhs   <= s1_dxp * s1_dy;
    s2_rhs   <= s1_dxe * s1_dyp;
  end

  // Compare direction flips with the sign of the edge's y difference.
  assign left = s2_dypos ? (s2_lhs < s2_rhs) : (s2_rhs < s2_lhs);

  always_ff @(posedge clk) begin
    if (start) begin
      parity <= 1'b0;
    end else if (s2_v && s2_str && left) begin
      parity <= ~parity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_inside <= parity;
    end
  end

endmodule

`default_nettype wire

[design/point_in_polygon_test.sv]
`default_nettype none
// Channel       Direction  Payload (low bit first)
// s_axis_*      in         tuser: command; tdata: vertex_index, x_coord, y_coord, zero pad
// m_axis_*      out        tdata: inside_res, zero pad
// cfg_*         in         data: vertex_count
//
// A query over n vertices makes one store read per vertex through a single read port,
// plus one read of the last vertex first to seed the previous vertex, then runs a
// three-stage difference, multiply and compare pipeline. A two-entry queue sits between
// the input and the engine, so up to two items are taken while a query runs or a result waits.
// Synchronous reset clears control state and vertex_count; the vertex store keeps
// its contents and is undefined until written.

module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  localparam int IDX_BITS = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int CNT_BITS = $clog2(MAX_VERTICES + 1),
  localparam int IN_BITS  = ((IDX_BITS + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [IN_BITS-1:0]  s_axis_tdata,   // vertex_index, x_coord, y_coord, pad
  input  wire logic                s_axis_tuser,   // command
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OUT_BITS-1:0]      m_axis_tdata,   // inside_res, pad
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CNT_BITS-1:0] cfg_data        // vertex_count
);

  localparam logic [CNT_BITS-1:0] MAX_N = CNT_BITS'(MAX_VERTICES);

  logic [CNT_BITS-1:0]   vertex_count;
  logic [CNT_BITS-1:0]   n_use;
  logic                  q_valid;
  logic                  q_ready;
  op_t                   q_op;
  logic [IDX_BITS-1:0]   q_index;
  logic [COORD_BITS-1:0] q_x;
  logic [COORD_BITS-1:0] q_y;
  logic                  res_inside;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  // Clamp the count to the store depth.
  assign n_use = (vertex_count > MAX_N) ? MAX_N : vertex_count;

  pip_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_command (s_axis_tuser),
    .in_index   (s_axis_tdata[IDX_BITS-1:0]),
    .in_x       (s_axis_tdata[IDX_BITS +: COORD_BITS]),
    .in_y       (s_axis_tdata[IDX_BITS + COORD_BITS +: COORD_BITS]),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_op       (q_op),
    .q_index    (q_index),
    .q_x        (q_x),
    .q_y        (q_y)
  );

  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .n_use      (n_use),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_op       (q_op),
    .q_index    (q_index),
    .q_x        (q_x),
    .q_y        (q_y),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_inside (res_inside)
  );

  assign m_axis_tdata = {{(OUT_BITS - 1){1'b0}}, res_inside};

endmodule

`default_nettype wire

[tb/tb_point_in_polygon_test.sv]
`default_nettype none

module tb_point_in_polygon_test;
  import pip_pkg::*;

  localparam int IN_BITS       = 40;
  localparam int CNT_BITS      = 5;
  localparam int IDLE_PCT      = 26;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 750;
  localparam int DIR_ROWS      = 22;
  localparam int WANT_CALC     = -1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               cmd;
    logic [3:0]         idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [4:0]         count;
    int                 want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata = '0;   // vertex_index, x_coord, y_coord, pad
  logic                s_axis_tuser = 1'b0; // command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;        // inside_res, pad
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CNT_BITS-1:0] cfg_data = '0;       // vertex_count

  // Predictor state: vertex store and count as the block should hold them.
  logic signed [15:0] poly_x [16];
  logic signed [15:0] poly_y [16];
  logic [4:0]         poly_count = '0;
  logic               inside_expected [$];
  logic               inside_want;
  int                 fail_count = 0;

  bit hold_req = 1'b0;
  bit calm     = 1'b0;

  row_t dir_rows [DIR_ROWS];

  point_in_polygon_test dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Even-odd crossing count over every edge, last vertex back to first.
  function automatic logic point_inside(input logic signed [15:0] px,
                                        input logic signed [15:0] py);
    int     n;
    int     j;
    longint dy;
    longint lhs;
    longint rhs;
    logic   flag;
    logic   crosses;
    n = (poly_count > 16) ? 16 : int'(poly_count);
    flag = 1'b0;
    if (n == 0) return 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      if ((poly_y[i] > py) != (poly_y[j] > py)) begin
        dy  = longint'(poly_y[j]) - longint'(poly_y[i]);
        lhs = (longint'(px) - longint'(poly_x[i])) * dy;
        rhs = (longint'(poly_x[j]) - longint'(poly_x[i])) *
              (longint'(py) - longint'(poly_y[i]));
        crosses = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
        if (crosses) flag = ~flag;
      end
      j = i;
    end
    return flag;
  endfunction

  function automatic logic signed [15:0] pick_coord(input int span);
    if ($urandom_range(0, 99) < 15) return 16'($urandom);
    return 16'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic push_item(input logic cmd, input logic [3:0] idx,
                           input logic signed [15:0] x, input logic signed [15:0] y,
                           input int want);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, y, x, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (cmd == CMD_WRITE) begin
      poly_x[idx] = x;
      poly_y[idx] = y;
    end else begin
      inside_expected.push_back((want < 0) ? point_inside(x, y) : want[0]);
    end
  endtask

  // Drop valid, wait for every pending result, then let trailing writes retire.
  task automatic settle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (inside_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (inside_expected.size() != 0) begin
      $error("inside_res: %0d results never arrived", inside_expected.size());
      fail_count++;
      inside_expected.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_count(input logic [4:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    poly_count = value;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (inside_expected.size() == 0) begin
        $error("inside_res: unexpected transfer, got %0d", m_axis_tdata[0]);
        fail_count++;
      end else begin
        inside_want = inside_expected.pop_front();
        if (m_axis_tdata[0] !== inside_want) begin
          $error("inside_res: expected %0d, got %0d", inside_want, m_axis_tdata[0]);
          fail_count++;
        end
      end
    end
  end

  // Result side: random back-pressure, one long hold while input keeps coming.
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        m_axis_tready <= 1'b0;
        held++;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int                 sent;
    int                 phase;
    int                 span;
    int                 n_items;
    int                 pick;
    logic [4:0]         cnt;
    logic [3:0]         idx;
    logic signed [15:0] qx;
    logic signed [15:0] qy;

    dir_rows = '{
      '{ROW_ITEM, CMD_QUERY, 4'd0,  16'sd0,      16'sd0,      5'd0, 0},  // empty polygon
      '{ROW_ITEM, CMD_QUERY, 4'd15, -16'sd32768, 16'sd32767,  5'd0, 0},
      '{ROW_ITEM, CMD_WRITE, 4'd0,  -16'sd100,   -16'sd100,   5'd0, WANT_CALC},
      '{ROW_ITEM, CMD_WRITE, 4'd1,  16'sd100,    -16'sd100,   5'd0, WANT_CALC},
      '{ROW_ITEM, CMD_WRITE, 4'd2,  16'sd100,    16'sd100,    5'd0, WANT_CALC},
      '{ROW_ITEM, CMD_WRITE, 4'd3,  -16'sd100,   16'sd100,    5'd0, WANT_CALC},
      '{ROW_CFG,  CMD_WRITE, 4'd0,  16'sd0,      16'sd0,      5'd1, WANT_CALC},
      '{ROW_ITEM, CMD_QUERY, 4'd0,  16'sd0,      16'sd0,      5'd0, 0},  // single vertex
      '{ROW_CFG,  CMD_WRITE, 4'd0,  16'sd0,      16'sd0,      5'd2, WANT_CALC},
      '{ROW_ITEM, CMD_QUERY, 4'd0,  16'sd0,      -16'sd100,   5'd0, 0},  // two vertices
      '{ROW_CFG,  CMD_WRITE, 4'd0,  16'sd0,      16'sd0,      5'd4, WANT_CALC},
      '{ROW_ITEM, CMD_QUERY, 4'd0,  16'sd0,      16'sd0,      5'd0, 1},
      '{ROW_ITEM, CMD_QUERY, 4'd0,  16'sd200,    16'sd0,      5'd0, 0},
      '{ROW_ITEM, CMD_QUERY, 4'd0,  16'sd32767,  16'sd32767,  5'd0, 0},
      '{ROW_ITEM, CMD_QUERY, 4'd0,  -16'sd32768, -16'sd32768, 5'd0, 0},
      '{ROW_ITEM, CMD_WRITE, 4'd0,  -16'sd32768, -16'sd32768, 5'd0, WANT_CALC},
      '{ROW_ITEM, CMD_WRITE, 4'd1,  16'sd32767,  -16'sd32768, 5'd0, WANT_CALC},
      '{ROW_ITEM, CMD_WRITE, 4'd2,  16'sd32767,  16'sd32767,  5'd0, WANT_CALC},
      '{ROW_ITEM, CMD_WRITE, 4'd3,  -16'sd32768, 16'sd32767,  5'd0, WANT_CALC},
      '{ROW_ITEM, CMD_QUERY, 4'd0,  16'sd0,      16'sd0,      5'd0, WANT_CALC},
      '{ROW_ITEM, CMD_QUERY, 4'd0,  -16'sd32768, 16'sd0,      5'd0, WANT_CALC},
      '{ROW_ITEM, CMD_QUERY, 4'd9,  16'sd32767,  -16'sd32768, 5'd0, WANT_CALC}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        load_count(dir_rows[r].count);
      end else begin
        push_item(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].x, dir_rows[r].y,
                  dir_rows[r].want);
      end
    end

    // Fill the rest of the store so that any count reads written entries only.
    for (int e = 4; e < 16; e++) begin
      push_item(CMD_WRITE, 4'(e), pick_coord(300), pick_coord(300), WANT_CALC);
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: cnt = 5'd31;
        1: cnt = 5'd16;
        2: cnt = 5'd0;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 6)      cnt = 5'($urandom_range(3, 8));
          else if (pick < 8) cnt = 5'($urandom_range(9, 16));
          else               cnt = 5'($urandom_range(0, 31));
        end
      endcase
      load_count(cnt);
      hold_req = (phase >= 4);
      calm     = (phase >= 7 && phase <= 9);
      case ($urandom_range(0, 2))
        0:       span = 8;
        1:       span = 200;
        default: span = 5000;
      endcase
      n_items = $urandom_range(15, 40);
      for (int k = 0; k < n_items; k++) begin
        idx = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 35) begin
          push_item(CMD_WRITE, idx, pick_coord(span), pick_coord(span), WANT_CALC);
        end else begin
          // Hit a vertex now and then: rays through vertices and along edges.
          if ($urandom_range(0, 99) < 20) begin
            qx = poly_x[idx];
            qy = poly_y[idx];
          end else begin
            qx = pick_coord(span);
            qy = pick_coord(span);
          end
          push_item(CMD_QUERY, idx, qx, qy, WANT_CALC);
        end
        sent++;
      end
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
